// ===== src/ecpr_pkg.sv =====
// Shared types, constants and the control store of the enhanced clock page replacer.
`timescale 1ns / 1ps
`default_nettype none

package ecpr_pkg;

  // Default geometry and fixed field widths.
  localparam int unsigned SlotsDefault    = 4;
  localparam int unsigned PageBitsDefault = 8;
  localparam int unsigned FaultBits       = 16;
  localparam int unsigned StepBits        = 3;

  typedef logic [StepBits-1:0] step_t;

  // Addresses of the control store.
  localparam step_t StepIdle   = 3'd0;
  localparam step_t StepLookup = 3'd1;
  localparam step_t StepHit    = 3'd2;
  localparam step_t StepMiss   = 3'd3;
  localparam step_t StepSweep  = 3'd4;
  localparam step_t StepLoad   = 3'd5;

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    ACT_ACCEPT,
    ACT_MARK,
    ACT_HIT,
    ACT_MISS,
    ACT_SWEEP,
    ACT_LOAD
  } act_e;

  // Condition that picks the next step.
  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_HIT,
    COND_EMPTY,
    COND_VICTIM,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // The microprogram: one control word per step.
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    case (step)
      StepIdle:   w = '{act: ACT_ACCEPT, cond: COND_IN_VALID,
                        on_true: StepLookup, on_false: StepIdle};
      StepLookup: w = '{act: ACT_MARK, cond: COND_HIT,
                        on_true: StepHit, on_false: StepMiss};
      StepHit:    w = '{act: ACT_HIT, cond: COND_OUT_FREE,
                        on_true: StepIdle, on_false: StepHit};
      StepMiss:   w = '{act: ACT_MISS, cond: COND_EMPTY,
                        on_true: StepLoad, on_false: StepSweep};
      StepSweep:  w = '{act: ACT_SWEEP, cond: COND_VICTIM,
                        on_true: StepLoad, on_false: StepSweep};
      StepLoad:   w = '{act: ACT_LOAD, cond: COND_OUT_FREE,
                        on_true: StepIdle, on_false: StepLoad};
      default:    w = '{act: ACT_ACCEPT, cond: COND_IN_VALID,
                        on_true: StepLookup, on_false: StepIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/enhanced_clock_page_replacer_unit.sv =====
// Enhanced second-chance clock page replacer, driven by a microcoded sequencer.
//
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries a page
// number and an optional mark that sets the modified bit of one occupied slot before
// the lookup. One result per request leaves on the output channel (out_valid_o /
// out_ready_i): hit flag, slot, evicted page and the saturating fault count.
// Sequence: a hit passes the idle, lookup and hit steps from acceptance to result. A miss
// into an empty slot at the hand goes from the miss step straight to the load step; a miss
// that needs a victim first runs the sweep loop of the control store, one slot per cycle,
// until a victim is found. After the result is registered the sequencer returns to the
// idle step, where the next request is taken, so a request is not accepted mid-operation.
// Reset empties every slot, clears all referenced and modified bits, the clock hand and
// the fault count; slot page numbers stay undefined until loaded.
// Receiver stall: the result waits in the output register while a new request is taken
// and looked up; the sequencer holds on its final step until the output is free.
`timescale 1ns / 1ps
`default_nettype none

module enhanced_clock_page_replacer_unit #(
  parameter int unsigned SLOTS     = ecpr_pkg::SlotsDefault,
  parameter int unsigned PAGE_BITS = ecpr_pkg::PageBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  page_number_i,
  input  wire logic        mark_valid_i,
  input  wire logic [1:0]  mark_slot_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [1:0]       slot_index_o,
  output logic             evicted_valid_o,
  output logic [7:0]       evicted_page_o,
  output logic [15:0]      fault_count_o
);

  localparam int unsigned SlotBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(SLOTS - 1);
  localparam logic [ecpr_pkg::FaultBits-1:0] FaultMax = '1;

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  // Sequencer state.
  ecpr_pkg::step_t  step_q;
  ecpr_pkg::uword_t uw;
  logic             cond_ok;

  // Frame table and replacement state.
  page_t              frame_page_q [SLOTS];
  logic [SLOTS-1:0]   valid_q, ref_q, mod_q;
  slot_t              hand_q, cnt_q;
  logic [1:0]         pass_q;
  logic [ecpr_pkg::FaultBits-1:0] fault_q;

  // Latched request.
  page_t              page_q;
  logic               mark_v_q;
  logic [1:0]         mark_slot_q;

  // Result register.
  logic               out_valid_q, out_hit_q, out_ev_valid_q;
  slot_t              out_slot_q;
  page_t              out_ev_page_q;
  logic [ecpr_pkg::FaultBits-1:0] out_fault_q;

  // Datapath flags.
  logic               hit_found;
  slot_t              hit_idx;
  logic               victim_ok;
  logic               out_free;
  logic               mark_ok;
  slot_t              mark_idx;
  slot_t              hand_next;

  // Parallel tag compare; the lowest-numbered matching slot wins.
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && frame_page_q[i] == page_q) begin
        hit_found = 1'b1;
        hit_idx   = SlotBits'(i);
      end
    end
  end

  // Slot under the hand and helper flags.
  assign victim_ok = !ref_q[hand_q] && (mod_q[hand_q] == pass_q[0]);
  assign hand_next = (hand_q == LastSlot) ? '0 : hand_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;
  assign mark_ok   = mark_v_q && (32'(mark_slot_q) < SLOTS);
  assign mark_idx  = SlotBits'(mark_slot_q);

  // Control word fetch and condition select.
  always_comb begin
    uw = ecpr_pkg::ucode_rom(step_q);
    case (uw.cond)
      ecpr_pkg::COND_IN_VALID: cond_ok = in_valid_i;
      ecpr_pkg::COND_HIT:      cond_ok = hit_found;
      ecpr_pkg::COND_EMPTY:    cond_ok = !valid_q[hand_q];
      ecpr_pkg::COND_VICTIM:   cond_ok = victim_ok;
      ecpr_pkg::COND_OUT_FREE: cond_ok = out_free;
      default:                 cond_ok = 1'b0;
    endcase
  end

  assign in_ready_o = (uw.act == ecpr_pkg::ACT_ACCEPT);

  // Control state, replacement bits, hand and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ecpr_pkg::StepIdle;
      valid_q     <= '0;
      ref_q       <= '0;
      mod_q       <= '0;
      hand_q      <= '0;
      cnt_q       <= '0;
      pass_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= cond_ok ? uw.on_true : uw.on_false;
      // The result is flagged when it is registered and dropped once it is taken.
      if (((uw.act == ecpr_pkg::ACT_HIT) || (uw.act == ecpr_pkg::ACT_LOAD)) && cond_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uw.act)
        ecpr_pkg::ACT_MARK: begin
          if (mark_ok && valid_q[mark_idx]) begin
            mod_q[mark_idx] <= 1'b1;
          end
        end
        ecpr_pkg::ACT_HIT: begin
          if (cond_ok) begin
            ref_q[hit_idx] <= 1'b1;
          end
        end
        ecpr_pkg::ACT_MISS: begin
          if (fault_q != FaultMax) begin
            fault_q <= fault_q + 1'b1;
          end
          cnt_q  <= '0;
          pass_q <= '0;
        end
        ecpr_pkg::ACT_SWEEP: begin
          if (!cond_ok) begin
            if (pass_q[0]) begin
              ref_q[hand_q] <= 1'b0;
            end
            hand_q <= hand_next;
            if (cnt_q == LastSlot) begin
              cnt_q  <= '0;
              pass_q <= pass_q + 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ecpr_pkg::ACT_LOAD: begin
          if (cond_ok) begin
            valid_q[hand_q] <= 1'b1;
            ref_q[hand_q]   <= 1'b1;
            mod_q[hand_q]   <= 1'b0;
            hand_q          <= hand_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Page store, latched request and result payload.
  always_ff @(posedge clk_i) begin
    case (uw.act)
      ecpr_pkg::ACT_ACCEPT: begin
        if (cond_ok) begin
          page_q      <= PAGE_BITS'(page_number_i);
          mark_v_q    <= mark_valid_i;
          mark_slot_q <= mark_slot_i;
        end
      end
      ecpr_pkg::ACT_HIT: begin
        if (cond_ok) begin
          out_hit_q      <= 1'b1;
          out_slot_q     <= hit_idx;
          out_ev_valid_q <= 1'b0;
          out_ev_page_q  <= '0;
          out_fault_q    <= fault_q;
        end
      end
      ecpr_pkg::ACT_LOAD: begin
        if (cond_ok) begin
          frame_page_q[hand_q] <= page_q;
          out_hit_q            <= 1'b0;
          out_slot_q           <= hand_q;
          out_ev_valid_q       <= valid_q[hand_q];
          out_ev_page_q        <= valid_q[hand_q] ? frame_page_q[hand_q] : '0;
          out_fault_q          <= fault_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Output ports.
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_index_o    = 2'(out_slot_q);
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = 8'(out_ev_page_q);
  assign fault_count_o   = out_fault_q;

`ifndef SYNTHESIS
  // A victim is always found before the pass counter wraps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_q == ecpr_pkg::StepSweep && pass_q == 2'd3 && cnt_q == LastSlot && !victim_ok))
    else $error("sweep ran out of passes without a victim");

  // A completed load leaves a miss result and an occupied slot behind the hand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ecpr_pkg::StepLoad && out_free)
      |=> (out_valid_q && !out_hit_q && valid_q[out_slot_q]))
    else $error("load did not produce a miss result on an occupied slot");

  // A completed hit reports a referenced, occupied slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ecpr_pkg::StepHit && out_free)
      |=> (out_valid_q && out_hit_q && ref_q[out_slot_q] && valid_q[out_slot_q]))
    else $error("hit result without a referenced slot");

  // The fault count moves only on the miss step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != $past(fault_q)) |-> ($past(step_q) == ecpr_pkg::StepMiss))
    else $error("fault count changed outside a miss");
`endif

endmodule

`default_nettype wire
